// File: hw/rtl/bcfr_pkg.sv
// Shared types, codes and helpers of the bus client call and frame receiver.
`timescale 1ns / 1ps
`default_nettype none
package bcfr_pkg;

	localparam int TIMER_WIDTH_DEF = 16;
	localparam int FRAME_BYTES_DEF = 16;
	localparam int IDX_W           = 5;
	localparam int PADDR_W         = 4;
	localparam int PDATA_W         = 32;
	localparam int NUM_SLOTS       = 8;

	localparam logic [4:0]  OWN_ADDR_RST  = 5'd0;
	localparam logic [15:0] CONN_TO_RST   = 16'd500;
	localparam logic [15:0] FRAME_TO_RST  = 16'd500;

	localparam logic [1:0] REG_OWN_ADDR = 2'd0;
	localparam logic [1:0] REG_CONN_TO  = 2'd1;
	localparam logic [1:0] REG_FRAME_TO = 2'd2;

	localparam logic OP_WORD = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam int CALL_BIT = 8;
	localparam logic [4:0] ADDR_BROADCAST = 5'd0;
	localparam logic [1:0] CALL_ACK       = 2'b00;
	localparam logic [1:0] CALL_FRAME     = 2'b11;

	localparam logic [1:0] KIND_EVENT = 2'd0;
	localparam logic [1:0] KIND_MSG   = 2'd1;
	localparam logic [1:0] KIND_TX    = 2'd2;
	localparam logic [1:0] KIND_CLEAR = 2'd3;

	localparam logic [3:0] EV_CONN_ERR   = 4'd0;
	localparam logic [3:0] EV_CONN_OK    = 4'd1;
	localparam logic [3:0] EV_ACK_REQ    = 4'd2;
	localparam logic [3:0] EV_RX_TIMEOUT = 4'd3;
	localparam logic [3:0] EV_XOR_ERR    = 4'd4;
	localparam logic [3:0] EV_OVERRUN    = 4'd5;
	localparam logic [3:0] EV_TX_ERR     = 4'd6;
	localparam logic [3:0] EV_UNKNOWN    = 4'd7;
	localparam logic [3:0] EV_BUSY       = 4'd8;

	localparam logic [7:0] ACK_BYTE      = 8'h20;
	localparam logic [7:0] REPLY_HDR     = 8'h61;
	localparam logic [7:0] REPLY_TX_ERR  = 8'h80;
	localparam logic [7:0] REPLY_BUSY    = 8'h81;
	localparam logic [7:0] REPLY_UNKNOWN = 8'h82;

	// result slots, in emission order
	localparam logic [2:0] SL_CLEAR    = 3'd0;
	localparam logic [2:0] SL_CONN_ERR = 3'd1;
	localparam logic [2:0] SL_RX_TO    = 3'd2;
	localparam logic [2:0] SL_CONN_OK  = 3'd3;
	localparam logic [2:0] SL_TX_HDR   = 3'd4;
	localparam logic [2:0] SL_TX_CHK   = 3'd5;
	localparam logic [2:0] SL_ACK_REQ  = 3'd6;
	localparam logic [2:0] SL_EVENT    = 3'd7;

	typedef struct packed {
		logic [NUM_SLOTS-1:0] mask;
		logic [3:0]           ev_code;
		logic [IDX_W-1:0]     msg_len;
	} job_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] value;
	} result_t;

	function automatic logic [2:0] low_slot(input logic [NUM_SLOTS-1:0] mask);
		logic [2:0] idx;
		idx = 3'd0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (mask[i]) begin
				idx = 3'(i);
			end
		end
		return idx;
	endfunction

	function automatic result_t slot_result(input logic [2:0] slot, input logic [3:0] ev_code);
		result_t r;
		r.kind  = KIND_EVENT;
		r.value = 8'd0;
		case (slot)
			SL_CLEAR: begin
				r.kind = KIND_CLEAR;
			end
			SL_CONN_ERR: r.value = 8'(EV_CONN_ERR);
			SL_RX_TO:    r.value = 8'(EV_RX_TIMEOUT);
			SL_CONN_OK:  r.value = 8'(EV_CONN_OK);
			SL_TX_HDR, SL_TX_CHK: begin
				r.kind  = KIND_TX;
				r.value = ACK_BYTE;
			end
			SL_ACK_REQ:  r.value = 8'(EV_ACK_REQ);
			default:     r.value = 8'(ev_code);
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// File: hw/rtl/bcfr_in_if.sv
// Input channel: received bus words and millisecond ticks.
`timescale 1ns / 1ps
`default_nettype none
interface bcfr_in_if;
	logic       valid;
	logic       ready;
	logic       operation;
	logic [8:0] bus_word;

	modport source (output valid, output operation, output bus_word, input ready);
	modport sink (input valid, input operation, input bus_word, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/bcfr_out_if.sv
// Output channel: events, message bytes and transmit commands.
`timescale 1ns / 1ps
`default_nettype none
interface bcfr_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] value;
	logic       last;

	modport source (output valid, output kind, output value, output last, input ready);
	modport sink (input valid, input kind, input value, input last, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/bcfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module bcfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/bcfr_front.sv
// Front end: accepts words and ticks, tracks link and frame state, issues result jobs.
`timescale 1ns / 1ps
`default_nettype none
module bcfr_front #(
	parameter int TIMER_WIDTH = bcfr_pkg::TIMER_WIDTH_DEF,
	parameter int FRAME_BYTES = bcfr_pkg::FRAME_BYTES_DEF,
	localparam int AW         = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	bcfr_in_if.sink                 rx,
	input  wire logic [4:0]         own_addr,
	input  wire logic [15:0]        conn_to,
	input  wire logic [15:0]        frame_to,
	input  wire logic               q_full,
	output logic                    q_wr,
	output bcfr_pkg::job_t          q_data,
	input  wire logic               msg_done,
	output logic                    ram_we,
	output logic [AW-1:0]           ram_waddr,
	output logic [7:0]              ram_wdata
);

	localparam int CW = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;
	localparam logic [TIMER_WIDTH-1:0] MS_MAX = '1;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_HEADER,
		PH_DATA
	} phase_t;

	phase_t                               phase_q, phase_n, phase_a;
	logic                                 link_q, link_n, link_a;
	logic                                 busy_q;
	logic [TIMER_WIDTH-1:0]               ms_q, ms_n, ms_inc;
	logic [bcfr_pkg::IDX_W-1:0]           idx_q, idx_n, idx_inc;
	logic [bcfr_pkg::IDX_W-1:0]           size_q, size_n;
	logic [7:0]                           chk_q, chk_n, chk_x;
	logic [7:0]                           b0_q, b0_n, b1_q, b1_n, b1_cur;
	logic [7:0]                           byte_w;
	logic                                 accept;
	bcfr_pkg::job_t                       job;

	assign rx.ready = !q_full && !busy_q;
	assign accept   = rx.valid && rx.ready;
	assign byte_w   = rx.bus_word[7:0];

	always_comb begin
		ms_inc = ms_q;
		if (rx.operation == bcfr_pkg::OP_TICK && ms_q != MS_MAX) begin
			ms_inc = ms_q + 1'b1;
		end
		ms_n     = ms_inc;
		link_a   = link_q;
		phase_a  = phase_q;
		job      = '0;
		idx_n    = idx_q;
		idx_inc  = idx_q + 1'b1;
		size_n   = size_q;
		chk_n    = chk_q;
		chk_x    = chk_q ^ byte_w;
		b0_n     = b0_q;
		b1_n     = b1_q;
		b1_cur   = (idx_q == bcfr_pkg::IDX_W'(1)) ? byte_w : b1_q;
		ram_we   = 1'b0;
		ram_waddr = idx_q[AW-1:0];
		ram_wdata = byte_w;

		if (!link_q && (CW'(ms_inc) > CW'(conn_to))) begin
			job.mask[bcfr_pkg::SL_CLEAR]    = 1'b1;
			job.mask[bcfr_pkg::SL_CONN_ERR] = 1'b1;
			link_a  = 1'b1;
			phase_a = PH_IDLE;
		end
		if (phase_a == PH_DATA && (CW'(ms_inc) >= CW'(frame_to))) begin
			job.mask[bcfr_pkg::SL_RX_TO] = 1'b1;
			phase_a = PH_IDLE;
		end
		link_n  = link_a;
		phase_n = phase_a;

		if (rx.operation == bcfr_pkg::OP_WORD) begin
			case (phase_a)
				PH_HEADER: begin
					ram_we    = 1'b1;
					ram_waddr = '0;
					b0_n      = byte_w;
					chk_n     = byte_w;
					size_n    = {1'b0, byte_w[3:0]} + 1'b1;
					idx_n     = bcfr_pkg::IDX_W'(1);
					phase_n   = PH_DATA;
				end
				PH_DATA: begin
					ram_we = 1'b1;
					chk_n  = chk_x;
					if (idx_q == bcfr_pkg::IDX_W'(1)) begin
						b1_n = byte_w;
					end
					if (idx_q == size_q) begin
						phase_n = PH_IDLE;
						if (chk_x != 8'd0) begin
							job.mask[bcfr_pkg::SL_EVENT] = 1'b1;
							job.ev_code = bcfr_pkg::EV_XOR_ERR;
						end else if (b0_q == bcfr_pkg::REPLY_HDR &&
								b1_cur == bcfr_pkg::REPLY_TX_ERR) begin
							job.mask[bcfr_pkg::SL_EVENT] = 1'b1;
							job.ev_code = bcfr_pkg::EV_TX_ERR;
						end else if (b0_q == bcfr_pkg::REPLY_HDR &&
								b1_cur == bcfr_pkg::REPLY_UNKNOWN) begin
							job.mask[bcfr_pkg::SL_EVENT] = 1'b1;
							job.ev_code = bcfr_pkg::EV_UNKNOWN;
						end else if (b0_q == bcfr_pkg::REPLY_HDR &&
								b1_cur == bcfr_pkg::REPLY_BUSY) begin
							job.mask[bcfr_pkg::SL_EVENT] = 1'b1;
							job.ev_code = bcfr_pkg::EV_BUSY;
						end else begin
							job.msg_len = size_q;
						end
					end else begin
						idx_n = idx_inc;
						if (idx_inc == bcfr_pkg::IDX_W'(FRAME_BYTES)) begin
							job.mask[bcfr_pkg::SL_EVENT] = 1'b1;
							job.ev_code = bcfr_pkg::EV_OVERRUN;
							phase_n = PH_IDLE;
						end
					end
				end
				default: begin
					phase_n = PH_IDLE;
					ms_n    = '0;
					if (rx.bus_word[bcfr_pkg::CALL_BIT]) begin
						job.mask[bcfr_pkg::SL_CONN_OK] = link_a;
						link_n = 1'b0;
						if (rx.bus_word[4:0] == bcfr_pkg::ADDR_BROADCAST) begin
							phase_n = PH_HEADER;
						end else if (rx.bus_word[4:0] == own_addr) begin
							case (rx.bus_word[6:5])
								bcfr_pkg::CALL_ACK: begin
									job.mask[bcfr_pkg::SL_TX_HDR]  = 1'b1;
									job.mask[bcfr_pkg::SL_TX_CHK]  = 1'b1;
									job.mask[bcfr_pkg::SL_ACK_REQ] = 1'b1;
								end
								bcfr_pkg::CALL_FRAME: phase_n = PH_HEADER;
								default: ;
							endcase
						end
					end
				end
			endcase
		end

		ram_we = ram_we && accept;
		q_wr   = accept && (job.mask != '0 || job.msg_len != '0);
		q_data = job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			link_q  <= 1'b0;
			busy_q  <= 1'b0;
			ms_q    <= '0;
			idx_q   <= '0;
			size_q  <= '0;
			chk_q   <= '0;
			b0_q    <= '0;
			b1_q    <= '0;
		end else begin
			if (accept) begin
				phase_q <= phase_n;
				link_q  <= link_n;
				ms_q    <= ms_n;
				idx_q   <= idx_n;
				size_q  <= size_n;
				chk_q   <= chk_n;
				b0_q    <= b0_n;
				b1_q    <= b1_n;
			end
			if (q_wr && job.msg_len != '0) begin
				busy_q <= 1'b1;
			end else if (msg_done) begin
				busy_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/bcfr_queue.sv
// Two-entry job queue between front and back end.
`timescale 1ns / 1ps
`default_nettype none
module bcfr_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr,
	input  bcfr_pkg::job_t     wr_data,
	output logic               full,
	input  wire logic          rd,
	output bcfr_pkg::job_t     rd_data,
	output logic               empty
);

	bcfr_pkg::job_t entry_q [2];
	logic           wptr_q, rptr_q;
	logic [1:0]     cnt_q;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign rd_data = entry_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			entry_q[wptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (wr) begin
				wptr_q <= !wptr_q;
			end
			if (rd) begin
				rptr_q <= !rptr_q;
			end
			case ({wr, rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/bcfr_back.sv
// Back end: expands jobs into results, streams stored frame bytes, drives the output register.
`timescale 1ns / 1ps
`default_nettype none
module bcfr_back #(
	parameter int FRAME_BYTES = bcfr_pkg::FRAME_BYTES_DEF,
	localparam int AW         = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  bcfr_pkg::job_t     q_data,
	input  wire logic          q_empty,
	output logic               q_rd,
	output logic               ram_re,
	output logic [AW-1:0]      ram_raddr,
	input  wire logic [7:0]    ram_rdata,
	output logic               msg_done,
	bcfr_out_if.source         res
);

	logic                                active_q;
	logic [bcfr_pkg::NUM_SLOTS-1:0]      mask_q, mask_rest;
	logic [3:0]                          ev_q;
	logic [bcfr_pkg::IDX_W-1:0]          rd_left_q, out_left_q, rd_ptr_q;
	logic                                have_q;
	logic                                out_v_q, out_last_q;
	logic [1:0]                          out_kind_q;
	logic [7:0]                          out_value_q;
	logic                                load_ok, ev_pick, byte_pick;
	logic [2:0]                          slot;
	bcfr_pkg::result_t                   slot_res;

	assign load_ok   = !out_v_q || res.ready;
	assign ev_pick   = active_q && mask_q != '0 && load_ok;
	assign byte_pick = active_q && mask_q == '0 && have_q && load_ok;
	assign ram_re    = active_q && rd_left_q != '0 && (!have_q || byte_pick);
	assign ram_raddr = rd_ptr_q[AW-1:0];
	assign q_rd      = !active_q && !q_empty;
	assign msg_done  = byte_pick && out_left_q == bcfr_pkg::IDX_W'(1);
	assign slot      = bcfr_pkg::low_slot(mask_q);
	assign slot_res  = bcfr_pkg::slot_result(slot, ev_q);

	always_comb begin
		mask_rest       = mask_q;
		mask_rest[slot] = 1'b0;
	end

	assign res.valid = out_v_q;
	assign res.kind  = out_kind_q;
	assign res.value = out_value_q;
	assign res.last  = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			mask_q      <= '0;
			ev_q        <= '0;
			rd_left_q   <= '0;
			out_left_q  <= '0;
			rd_ptr_q    <= '0;
			have_q      <= 1'b0;
			out_v_q     <= 1'b0;
			out_last_q  <= 1'b0;
			out_kind_q  <= '0;
			out_value_q <= '0;
		end else begin
			if (q_rd) begin
				active_q   <= 1'b1;
				mask_q     <= q_data.mask;
				ev_q       <= q_data.ev_code;
				rd_left_q  <= q_data.msg_len;
				out_left_q <= q_data.msg_len;
				rd_ptr_q   <= '0;
				have_q     <= 1'b0;
			end else if (active_q && mask_q == '0 && out_left_q == '0) begin
				active_q <= 1'b0;
			end

			if (ev_pick) begin
				mask_q <= mask_rest;
			end

			if (ram_re) begin
				rd_ptr_q  <= rd_ptr_q + 1'b1;
				rd_left_q <= rd_left_q - 1'b1;
				have_q    <= 1'b1;
			end else if (byte_pick) begin
				have_q <= 1'b0;
			end

			if (byte_pick) begin
				out_left_q <= out_left_q - 1'b1;
			end

			if (ev_pick) begin
				out_v_q     <= 1'b1;
				out_kind_q  <= slot_res.kind;
				out_value_q <= slot_res.value;
				out_last_q  <= (mask_rest == '0) && (out_left_q == '0);
			end else if (byte_pick) begin
				out_v_q     <= 1'b1;
				out_kind_q  <= bcfr_pkg::KIND_MSG;
				out_value_q <= ram_rdata;
				out_last_q  <= (out_left_q == bcfr_pkg::IDX_W'(1));
			end else if (res.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/bus_client_call_and_frame_receiver_core.sv
// Top level of the bus client call and frame receiver.
//
// Channel rx carries one item per transfer: a received 9-bit bus word (operation 0)
// or a one millisecond tick (operation 1). Channel res returns the results of each
// item, one per transfer, with last set on the final one; an item that causes no
// result returns nothing. The APB port holds own address and the two timeouts.
//
// An item's job is written into the job queue, then loaded into the back end, and
// its result is registered in the output register; a message byte is first read
// from the frame RAM. While res is ready, events come one per cycle; a completed
// frame streams its stored bytes one per cycle from the frame RAM, with the RAM's
// read latency hidden by prefetch. The front takes an item every cycle while the
// two-entry job queue has room and no frame's message bytes are still pending;
// items without results never use the queue. The back end takes a new job only
// after it has emitted every result of its current job.
//
// Reset clears link, timer and frame state, the queue and the output register;
// the frame RAM is not cleared and is read only at positions written in the
// current frame. When res stalls, the output register holds its result, the back
// end waits and the queue fills, after which rx drops ready.
`timescale 1ns / 1ps
`default_nettype none
module bus_client_call_and_frame_receiver_core #(
	parameter int TIMER_WIDTH = bcfr_pkg::TIMER_WIDTH_DEF,
	parameter int FRAME_BYTES = bcfr_pkg::FRAME_BYTES_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	bcfr_in_if.sink                           rx,
	bcfr_out_if.source                        res,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [bcfr_pkg::PADDR_W-1:0] paddr,
	input  wire logic [bcfr_pkg::PDATA_W-1:0] pwdata,
	output logic      [bcfr_pkg::PDATA_W-1:0] prdata,
	output logic                              pready
);

	localparam int AW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;

	logic [4:0]     own_addr_q;
	logic [15:0]    conn_to_q, frame_to_q;
	logic           wr_en;
	logic [1:0]     reg_idx;

	logic           q_wr, q_rd, q_full, q_empty, msg_done;
	bcfr_pkg::job_t q_wdata, q_rdata;
	logic           ram_we, ram_re;
	logic [AW-1:0]  ram_waddr, ram_raddr;
	logic [7:0]     ram_wdata, ram_rdata;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = paddr[3:2];

	always_comb begin
		case (reg_idx)
			bcfr_pkg::REG_OWN_ADDR: prdata = bcfr_pkg::PDATA_W'(own_addr_q);
			bcfr_pkg::REG_CONN_TO:  prdata = bcfr_pkg::PDATA_W'(conn_to_q);
			bcfr_pkg::REG_FRAME_TO: prdata = bcfr_pkg::PDATA_W'(frame_to_q);
			default:                prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_addr_q <= bcfr_pkg::OWN_ADDR_RST;
			conn_to_q  <= bcfr_pkg::CONN_TO_RST;
			frame_to_q <= bcfr_pkg::FRAME_TO_RST;
		end else if (wr_en) begin
			case (reg_idx)
				bcfr_pkg::REG_OWN_ADDR: own_addr_q <= pwdata[4:0];
				bcfr_pkg::REG_CONN_TO:  conn_to_q  <= pwdata[15:0];
				bcfr_pkg::REG_FRAME_TO: frame_to_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	bcfr_front #(
		.TIMER_WIDTH (TIMER_WIDTH),
		.FRAME_BYTES (FRAME_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx),
		.own_addr  (own_addr_q),
		.conn_to   (conn_to_q),
		.frame_to  (frame_to_q),
		.q_full    (q_full),
		.q_wr      (q_wr),
		.q_data    (q_wdata),
		.msg_done  (msg_done),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata)
	);

	bcfr_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_wr),
		.wr_data (q_wdata),
		.full    (q_full),
		.rd      (q_rd),
		.rd_data (q_rdata),
		.empty   (q_empty)
	);

	bcfr_ram #(
		.WIDTH (8),
		.DEPTH (FRAME_BYTES)
	) u_frame_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	bcfr_back #(
		.FRAME_BYTES (FRAME_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_data    (q_rdata),
		.q_empty   (q_empty),
		.q_rd      (q_rd),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.msg_done  (msg_done),
		.res       (res)
	);

endmodule
`default_nettype wire

// File: hw/rtl/bcfr_checker.sv
// Port-level checks of the result channel, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module bcfr_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       res_valid,
	input wire logic       res_ready,
	input wire logic [1:0] res_kind,
	input wire logic [7:0] res_value,
	input wire logic       res_last
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_kind) &&
			$stable(res_value) && $stable(res_last))
		else $error("result changed while stalled");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_kind == bcfr_pkg::KIND_CLEAR |-> !res_last && res_value == 8'd0)
		else $error("bad clear transfer");

	a_clear_then_err: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && res_kind == bcfr_pkg::KIND_CLEAR |=>
			res_valid && res_kind == bcfr_pkg::KIND_EVENT &&
			res_value == 8'(bcfr_pkg::EV_CONN_ERR))
		else $error("clear not followed by connection error");

	a_tx: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_kind == bcfr_pkg::KIND_TX |-> res_value == bcfr_pkg::ACK_BYTE &&
			!res_last)
		else $error("bad transmit transfer");

	a_event: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_kind == bcfr_pkg::KIND_EVENT |->
			res_value <= 8'(bcfr_pkg::EV_BUSY))
		else $error("event code out of range");

endmodule

bind bus_client_call_and_frame_receiver_core bcfr_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_kind  (res.kind),
	.res_value (res.value),
	.res_last  (res.last)
);
`default_nettype wire

// File: verif/bcfr_result_checker.sv
// Result checker for the bus client receiver: predicts each transfer's results and compares them.
`timescale 1ns / 1ps
module bcfr_result_checker
	import bcfr_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               rx_valid,
	input  wire logic               rx_ready,
	input  wire logic               rx_operation,
	input  wire logic [8:0]         rx_bus_word,
	input  wire logic               res_valid,
	input  wire logic               res_ready,
	input  wire logic [1:0]         res_kind,
	input  wire logic [7:0]         res_value,
	input  wire logic               res_last,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	input  wire logic               pready,
	output int                      owed_count,
	output int                      checked_count,
	output int                      fail_count
);

	typedef enum logic [1:0] {
		WAIT_CALL  = 2'd0,
		GET_HEADER = 2'd1,
		GET_DATA   = 2'd2
	} rx_phase_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] value;
		logic       last;
	} bus_result_t;

	logic [4:0]  own_addr;
	logic [15:0] conn_limit;
	logic [15:0] frame_limit;
	rx_phase_t   phase;
	logic        link_lost;
	logic [15:0] quiet_ms;
	logic [4:0]  byte_pos;
	logic [4:0]  frame_len;
	logic [7:0]  xor_sum;
	logic [7:0]  frame_buf [16];
	bus_result_t owed_results [$];
	int          owed_n = 0;
	int          checked_n = 0;
	int          fails = 0;

	assign owed_count    = owed_n;
	assign checked_count = checked_n;
	assign fail_count    = fails;

	task automatic push_result(input logic [1:0] kind, input logic [7:0] value);
		bus_result_t r;
		r.kind  = kind;
		r.value = value;
		r.last  = 1'b0;
		owed_results.push_back(r);
	endtask

	task automatic push_event(input logic [3:0] code);
		push_result(KIND_EVENT, {4'd0, code});
	endtask

	task automatic call_word(input logic [8:0] word);
		quiet_ms = '0;
		phase = WAIT_CALL;
		if (word[CALL_BIT]) begin
			if (link_lost) begin
				push_event(EV_CONN_OK);
			end
			link_lost = 1'b0;
			if (word[4:0] == ADDR_BROADCAST) begin
				phase = GET_HEADER;
			end else if (word[4:0] == own_addr) begin
				if (word[6:5] == CALL_ACK) begin
					push_result(KIND_TX, ACK_BYTE);
					push_result(KIND_TX, ACK_BYTE);
					push_event(EV_ACK_REQ);
				end else if (word[6:5] == CALL_FRAME) begin
					phase = GET_HEADER;
				end
			end
		end
	endtask

	task automatic close_frame();
		phase = WAIT_CALL;
		if (xor_sum != 8'd0) begin
			push_event(EV_XOR_ERR);
		end else if (frame_buf[0] == REPLY_HDR && frame_buf[1] == REPLY_TX_ERR) begin
			push_event(EV_TX_ERR);
		end else if (frame_buf[0] == REPLY_HDR && frame_buf[1] == REPLY_UNKNOWN) begin
			push_event(EV_UNKNOWN);
		end else if (frame_buf[0] == REPLY_HDR && frame_buf[1] == REPLY_BUSY) begin
			push_event(EV_BUSY);
		end else begin
			for (int i = 0; i < frame_len; i++) begin
				push_result(KIND_MSG, frame_buf[i]);
			end
		end
	endtask

	task automatic decode_item(input logic op, input logic [8:0] word);
		int          n_prior;
		logic [7:0]  b;
		bus_result_t tail;
		n_prior = owed_results.size();
		b = word[7:0];
		if (op == OP_TICK && quiet_ms != 16'hFFFF) begin
			quiet_ms = quiet_ms + 16'd1;
		end
		if (!link_lost && quiet_ms > conn_limit) begin
			push_result(KIND_CLEAR, 8'd0);
			push_event(EV_CONN_ERR);
			link_lost = 1'b1;
			phase = WAIT_CALL;
		end
		if (phase == GET_DATA && quiet_ms >= frame_limit) begin
			push_event(EV_RX_TIMEOUT);
			phase = WAIT_CALL;
		end
		if (op == OP_WORD) begin
			case (phase)
				GET_HEADER: begin
					frame_buf[0] = b;
					xor_sum = b;
					frame_len = {1'b0, b[3:0]} + 5'd1;
					byte_pos = 5'd1;
					phase = GET_DATA;
				end
				GET_DATA: begin
					frame_buf[byte_pos[3:0]] = b;
					xor_sum = xor_sum ^ b;
					if (byte_pos == frame_len) begin
						close_frame();
					end else begin
						byte_pos = byte_pos + 5'd1;
						if (byte_pos == 5'd16) begin
							push_event(EV_OVERRUN);
							phase = WAIT_CALL;
						end
					end
				end
				default: call_word(word);
			endcase
		end
		if (owed_results.size() > n_prior) begin
			tail = owed_results.pop_back();
			tail.last = 1'b1;
			owed_results.push_back(tail);
		end
	endtask

	task automatic check_result(input logic [1:0] kind, input logic [7:0] value, input logic last);
		bus_result_t want;
		checked_n++;
		if (owed_results.size() == 0) begin
			fails++;
			$display("%0t: unexpected result: expected none, got kind %0d value 0x%02h last %0b",
				$time, kind, value, last);
		end else begin
			want = owed_results.pop_front();
			if (kind !== want.kind || value !== want.value || last !== want.last) begin
				fails++;
				$display("%0t: result mismatch: expected kind %0d value 0x%02h last %0b, got kind %0d value 0x%02h last %0b",
					$time, want.kind, want.value, want.last, kind, value, last);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_addr    = OWN_ADDR_RST;
			conn_limit  = CONN_TO_RST;
			frame_limit = FRAME_TO_RST;
			phase       = WAIT_CALL;
			link_lost   = 1'b0;
			quiet_ms    = '0;
			byte_pos    = '0;
			frame_len   = '0;
			xor_sum     = '0;
			owed_results.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_OWN_ADDR: own_addr = pwdata[4:0];
					REG_CONN_TO:  conn_limit = pwdata[15:0];
					REG_FRAME_TO: frame_limit = pwdata[15:0];
					default: ;
				endcase
			end
			if (rx_valid && rx_ready) begin
				decode_item(rx_operation, rx_bus_word);
			end
			if (res_valid && res_ready) begin
				check_result(res_kind, res_value, res_last);
			end
		end
		owed_n = owed_results.size();
	end

endmodule

// File: verif/bus_client_call_and_frame_receiver_core_test.sv
// Testbench top for the bus client receiver: drives calls, frames, ticks and register writes.
`timescale 1ns / 1ps
module bus_client_call_and_frame_receiver_core_test;
	import bcfr_pkg::*;

	localparam int HOLD_OFF_CYCLES = 300;
	localparam int DRAIN_CYCLES    = 12;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	bit                 calm;
	bit                 hold_off;
	int                 items_sent;
	int                 settings_used;
	int                 tick_pct;
	int                 burst_max;
	logic [4:0]         slot_addr;
	int                 owed_count;
	int                 checked_count;
	int                 fail_count;

	bcfr_in_if  rx_ch ();
	bcfr_out_if res_ch ();

	bus_client_call_and_frame_receiver_core u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx      (rx_ch),
		.res     (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	bcfr_result_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.rx_valid      (rx_ch.valid),
		.rx_ready      (rx_ch.ready),
		.rx_operation  (rx_ch.operation),
		.rx_bus_word   (rx_ch.bus_word),
		.res_valid     (res_ch.valid),
		.res_ready     (res_ch.ready),
		.res_kind      (res_ch.kind),
		.res_value     (res_ch.value),
		.res_last      (res_ch.last),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.pready        (pready),
		.owed_count    (owed_count),
		.checked_count (checked_count),
		.fail_count    (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("%0t: run timed out, %0d results still outstanding", $time, owed_count);
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		int stall;
		int pick;
		res_ch.ready = 1'b0;
		stall = 0;
		forever begin
			@(posedge clk);
			if (hold_off) begin
				res_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off = 1'b0;
			end else if (stall > 0) begin
				res_ch.ready <= 1'b0;
				stall--;
			end else begin
				res_ch.ready <= 1'b1;
				if (!calm) begin
					pick = $urandom_range(0, 99);
					if (pick < 4) begin
						stall = $urandom_range(15, 50);
					end else if (pick < 20) begin
						stall = $urandom_range(1, 3);
					end
				end
			end
		end
	end

	task automatic send_item(input logic op, input logic [8:0] word);
		int gap;
		int pick;
		pick = $urandom_range(0, 99);
		gap = 0;
		if (!calm) begin
			if (pick >= 93) begin
				gap = $urandom_range(10, 40);
			end else if (pick >= 60) begin
				gap = $urandom_range(1, 3);
			end
		end
		if (gap > 0) begin
			rx_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_ch.valid     <= 1'b1;
		rx_ch.operation <= op;
		rx_ch.bus_word  <= word;
		do @(negedge clk); while (rx_ch.ready !== 1'b1);
		@(posedge clk);
		items_sent++;
	endtask

	task automatic send_frame(input logic [8:0] call, input logic [7:0] header, input bit good,
			input int pct);
		logic [7:0] chk;
		logic [7:0] b;
		send_item(OP_WORD, call);
		send_item(OP_WORD, {1'($urandom), header});
		chk = header;
		for (int i = 0; i < header[3:0]; i++) begin
			b = 8'($urandom);
			chk = chk ^ b;
			if ($urandom_range(0, 99) < pct) begin
				send_item(OP_TICK, 9'($urandom));
			end
			send_item(OP_WORD, {1'($urandom), b});
		end
		if (!good) begin
			chk = chk ^ 8'($urandom_range(1, 255));
		end
		send_item(OP_WORD, {1'($urandom), chk});
	endtask

	task automatic send_reply_frame(input logic [8:0] call, input logic [7:0] code);
		send_item(OP_WORD, call);
		send_item(OP_WORD, {1'($urandom), REPLY_HDR});
		send_item(OP_WORD, {1'($urandom), code});
		send_item(OP_WORD, {1'($urandom), REPLY_HDR ^ code});
	endtask

	task automatic write_reg(input logic [1:0] index, input logic [15:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {index, 2'b00};
		pwdata  <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(negedge clk); while (pready !== 1'b1);
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic settle();
		rx_ch.valid <= 1'b0;
		do @(negedge clk); while (owed_count != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apply_setting(input logic [4:0] own, input logic [15:0] conn,
			input logic [15:0] frame);
		settle();
		write_reg(REG_OWN_ADDR, 16'(own));
		write_reg(REG_CONN_TO, conn);
		write_reg(REG_FRAME_TO, frame);
		slot_addr = own;
		settings_used++;
	endtask

	task automatic random_sequence();
		int         pick;
		int         n;
		logic [8:0] call;
		logic [3:0] nib;
		logic [7:0] code;
		pick = $urandom_range(0, 99);
		if ($urandom_range(0, 1) != 0) begin
			call = {1'b1, 3'($urandom), ADDR_BROADCAST};
		end else begin
			call = {1'b1, 1'($urandom), CALL_FRAME, slot_addr};
		end
		if (pick < 40) begin
			n = $urandom_range(0, 99);
			if (n < 10) begin
				nib = 4'hF;
			end else if (n < 80) begin
				nib = 4'($urandom_range(0, 5));
			end else begin
				nib = 4'($urandom_range(6, 14));
			end
			send_frame(call, {4'($urandom), nib}, $urandom_range(0, 9) != 0, tick_pct);
		end else if (pick < 50) begin
			n = $urandom_range(0, 2);
			code = (n == 0) ? REPLY_TX_ERR : (n == 1) ? REPLY_BUSY : REPLY_UNKNOWN;
			send_reply_frame(call, code);
		end else if (pick < 62) begin
			send_item(OP_WORD, {1'b1, 1'($urandom), CALL_ACK, slot_addr});
		end else if (pick < 67) begin
			send_item(OP_WORD, {1'b1, 1'($urandom), 2'($urandom_range(1, 2)), slot_addr});
		end else if (pick < 72) begin
			send_item(OP_WORD, {1'b1, 3'($urandom), 5'($urandom_range(1, 31))});
		end else if (pick < 85) begin
			repeat ($urandom_range(1, burst_max)) send_item(OP_TICK, 9'($urandom));
		end else begin
			repeat ($urandom_range(1, 3)) send_item(1'($urandom), 9'($urandom));
		end
	endtask

	task automatic run_phase(input int count);
		int goal;
		goal = items_sent + count;
		while (items_sent < goal) begin
			if ($urandom_range(0, 11) == 0) begin
				calm = !calm;
			end
			random_sequence();
		end
		calm = 1'b0;
	endtask

	initial begin
		arst_n          = 1'b0;
		rx_ch.valid     = 1'b0;
		rx_ch.operation = OP_WORD;
		rx_ch.bus_word  = '0;
		psel            = 1'b0;
		penable         = 1'b0;
		pwrite          = 1'b0;
		paddr           = '0;
		pwdata          = '0;
		calm            = 1'b0;
		hold_off        = 1'b0;
		items_sent      = 0;
		settings_used   = 0;
		tick_pct        = 0;
		burst_max       = 4;
		slot_addr       = OWN_ADDR_RST;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		apply_setting(5'd7, 16'd4, 16'd2);
		send_item(OP_WORD, 9'h0FF);
		send_item(OP_WORD, {1'b1, 1'b0, CALL_ACK, 5'd7});
		send_item(OP_WORD, {1'b1, 1'b0, 2'b01, 5'd7});
		send_item(OP_WORD, {1'b1, 3'b000, 5'd8});
		send_reply_frame({1'b1, 3'b000, ADDR_BROADCAST}, REPLY_TX_ERR);
		send_reply_frame({1'b1, 1'b0, CALL_FRAME, 5'd7}, REPLY_UNKNOWN);
		send_reply_frame({1'b1, 3'b111, ADDR_BROADCAST}, REPLY_BUSY);
		send_frame({1'b1, 3'b000, ADDR_BROADCAST}, 8'hF2, 1'b1, 0);
		send_frame({1'b1, 3'b000, ADDR_BROADCAST}, 8'h30, 1'b0, 0);
		send_item(OP_WORD, {1'b1, 3'b000, ADDR_BROADCAST});
		send_item(OP_WORD, 9'h003);
		repeat (5) send_item(OP_TICK, 9'h1FF);
		send_item(OP_WORD, {1'b1, 3'b000, 5'd31});

		apply_setting(5'd31, 16'd1, 16'd1);
		tick_pct  = 10;
		burst_max = 3;
		run_phase(40);

		apply_setting(5'd5, 16'd30, 16'd6);
		tick_pct  = 15;
		burst_max = 12;
		hold_off  = 1'b1;
		repeat (4) send_frame({1'b1, 3'($urandom), ADDR_BROADCAST}, 8'h4C, 1'b1, 0);
		run_phase(50);

		apply_setting(5'd0, 16'd65535, 16'd65535);
		tick_pct  = 5;
		burst_max = 8;
		run_phase(40);

		apply_setting(5'($urandom_range(1, 31)), 16'($urandom_range(8, 40)),
			16'($urandom_range(2, 10)));
		tick_pct  = 12;
		burst_max = 10;
		run_phase(80);

		settle();
		$display("Sent %0d transfers under %0d register settings, %0d results compared.",
			items_sent, settings_used, checked_count);
		$display("Covered acks, fixed replies, message frames, check and overrun errors, timeouts.");
		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// File: bus_client_call_and_frame_receiver_core.f
hw/rtl/bcfr_pkg.sv
hw/rtl/bcfr_in_if.sv
hw/rtl/bcfr_out_if.sv
hw/rtl/bcfr_ram.sv
hw/rtl/bcfr_front.sv
hw/rtl/bcfr_queue.sv
hw/rtl/bcfr_back.sv
hw/rtl/bus_client_call_and_frame_receiver_core.sv
hw/rtl/bcfr_checker.sv
verif/bcfr_result_checker.sv
verif/bus_client_call_and_frame_receiver_core_test.sv
